// ===== hw/rtl/sacsc_pkg.sv =====
package sacsc_pkg;

	// Command codes of an input beat. Code three is handled as a read.
	localparam logic [1:0] CMD_READ    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_PRELOAD = 2'd2;

	// Outcome codes of a result beat.
	localparam logic [1:0] OUT_HIT        = 2'd0;
	localparam logic [1:0] OUT_MISS_CLEAN = 2'd1;
	localparam logic [1:0] OUT_MISS_DIRTY = 2'd2;
	localparam logic [1:0] OUT_PRELOAD    = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic latch;
		logic meta_rd;
		logic preload_wr;
		logic tag_cap;
		logic hit_upd;
		logic emit_write_hit;
		logic emit_read_hit;
		logic wb_rd;
		logic wb_wr;
		logic fill_rd;
		logic fill_wr;
		logic fin_upd;
	} sacsc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic is_preload;
		logic is_write;
		logic hit;
		logic victim_dirty;
		logic idx_last;
	} sacsc_stat_t;

endpackage

// ===== hw/rtl/sacsc_ctrl.sv =====
module sacsc_ctrl import sacsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  sacsc_stat_t stat,
	output sacsc_cmd_t  cmd
);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DISP   = 4'd2;
	localparam logic [3:0] S_TAG    = 4'd3;
	localparam logic [3:0] S_HITRD  = 4'd4;
	localparam logic [3:0] S_WBRD   = 4'd5;
	localparam logic [3:0] S_WBWR   = 4'd6;
	localparam logic [3:0] S_FILLRD = 4'd7;
	localparam logic [3:0] S_FILLWR = 4'd8;
	localparam logic [3:0] S_UPD    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.is_preload) begin
					cmd.preload_wr = 1'b1;
					state_d        = S_IDLE;
				end else begin
					cmd.meta_rd = 1'b1;
					state_d     = S_TAG;
				end
			end
			S_TAG: begin
				cmd.tag_cap = 1'b1;
				if (stat.hit) begin
					cmd.hit_upd = 1'b1;
					if (stat.is_write) begin
						cmd.emit_write_hit = 1'b1;
						state_d            = S_IDLE;
					end else begin
						state_d = S_HITRD;
					end
				end else if (stat.victim_dirty) begin
					state_d = S_WBRD;
				end else begin
					state_d = S_FILLRD;
				end
			end
			S_HITRD: begin
				cmd.emit_read_hit = 1'b1;
				state_d           = S_IDLE;
			end
			S_WBRD: begin
				cmd.wb_rd = 1'b1;
				state_d   = S_WBWR;
			end
			S_WBWR: begin
				cmd.wb_wr = 1'b1;
				state_d   = stat.idx_last ? S_FILLRD : S_WBRD;
			end
			S_FILLRD: begin
				cmd.fill_rd = 1'b1;
				state_d     = S_FILLWR;
			end
			S_FILLWR: begin
				cmd.fill_wr = 1'b1;
				state_d     = stat.idx_last ? S_UPD : S_FILLRD;
			end
			S_UPD: begin
				cmd.fin_upd = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/sacsc_dp.sv =====
module sacsc_dp import sacsc_pkg::*; #(
	parameter int WAYS       = 4,
	parameter int SETS       = 256,
	parameter int LINE_WORDS = 16,
	parameter int MEM_WORDS  = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sacsc_cmd_t         cmd,
	output sacsc_stat_t        stat,
	input  logic [1:0]         command,
	input  logic [31:0]        address,
	input  logic signed [31:0] write_data,
	output logic               done,
	output logic signed [31:0] read_data,
	output logic [1:0]         outcome
);

	localparam int WAY_W   = $clog2(WAYS);
	localparam int SET_W   = $clog2(SETS);
	localparam int WORD_W  = $clog2(LINE_WORDS);
	localparam int MEM_W   = $clog2(MEM_WORDS);
	localparam int TAG_W   = 30 - WORD_W - SET_W;
	localparam int ENTRY_W = TAG_W + 3;
	localparam int ROW_W   = WAYS * ENTRY_W + WAY_W;
	localparam int LINE_AW = WAY_W + SET_W + WORD_W;

	// Per-set metadata row: one entry {ref, dirty, valid, tag} per way, pointer on top.
	logic [ROW_W-1:0] meta_mem [SETS];
	logic [31:0]      line_mem [2**LINE_AW];
	logic [31:0]      back_mem [MEM_WORDS];

	logic [ROW_W-1:0]  meta_rd_q;
	logic [31:0]       line_rd_q;
	logic [31:0]       mem_rd_q;

	logic [1:0]        cmd_q;
	logic [WORD_W-1:0] word_q;
	logic [SET_W-1:0]  set_q;
	logic [TAG_W-1:0]  tag_q;
	logic [MEM_W-1:0]  waddr_q;
	logic [31:0]       wdata_q;

	logic [MEM_W-1:0]  clr_cnt_q;
	logic [WORD_W-1:0] idx_q;
	logic [WAY_W-1:0]  way_q;
	logic [TAG_W-1:0]  vic_tag_q;
	logic              vic_dirty_q;
	logic [WAYS-1:0]   ref_clr_q;
	logic [31:0]       miss_word_q;

	logic              done_q;
	logic [31:0]       read_data_q;
	logic [1:0]        outcome_q;

	logic [TAG_W-1:0]  e_tag [WAYS];
	logic [WAYS-1:0]   e_val;
	logic [WAYS-1:0]   e_dirty;
	logic [WAYS-1:0]   e_ref;
	logic [WAY_W-1:0]  ptr;
	logic              hit;
	logic [WAY_W-1:0]  hit_way;
	logic [WAY_W-1:0]  vic_way;
	logic [WAYS-1:0]   ref_new;
	logic              found;
	logic [ROW_W-1:0]  hit_row;
	logic [ROW_W-1:0]  fin_row;
	logic [WAY_W-1:0]  ptr_next;

	logic              is_write;
	logic              word_match;
	logic [31:0]       fill_data;
	logic [29:0]       wb_line;

	logic              meta_we;
	logic [SET_W-1:0]  meta_wa;
	logic [ROW_W-1:0]  meta_wd;
	logic              line_we;
	logic [LINE_AW-1:0] line_wa;
	logic [31:0]       line_wd;
	logic              line_re;
	logic [LINE_AW-1:0] line_ra;
	logic              back_we;
	logic [MEM_W-1:0]  back_wa;
	logic [31:0]       back_wd;

	assign is_write   = (cmd_q == CMD_WRITE);
	assign word_match = (idx_q == word_q);
	assign fill_data  = (is_write && word_match) ? wdata_q : mem_rd_q;
	assign wb_line    = {vic_tag_q, set_q, idx_q};

	// Decode the metadata row, find the hit way and walk the second-chance pointer.
	always_comb begin
		ptr     = meta_rd_q[ROW_W-1 -: WAY_W];
		hit     = 1'b0;
		hit_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			e_tag[w]   = meta_rd_q[w*ENTRY_W +: TAG_W];
			e_val[w]   = meta_rd_q[w*ENTRY_W + TAG_W];
			e_dirty[w] = meta_rd_q[w*ENTRY_W + TAG_W + 1];
			e_ref[w]   = meta_rd_q[w*ENTRY_W + TAG_W + 2];
		end
		for (int w = 0; w < WAYS; w++) begin
			if (!hit && e_val[w] && (e_tag[w] == tag_q)) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
		ref_new = e_ref;
		found   = 1'b0;
		vic_way = ptr;
		for (int n = 0; n < WAYS; n++) begin
			if (!found) begin
				if (!ref_new[vic_way]) begin
					found = 1'b1;
				end else begin
					ref_new[vic_way] = 1'b0;
					vic_way = (vic_way == WAY_W'(WAYS - 1)) ? '0 : vic_way + 1'b1;
				end
			end
		end
	end

	// Rows written back to the metadata memory.
	always_comb begin
		hit_row  = meta_rd_q;
		fin_row  = meta_rd_q;
		ptr_next = (way_q == WAY_W'(WAYS - 1)) ? '0 : way_q + 1'b1;
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) == hit_way) begin
				if (is_write) begin
					hit_row[w*ENTRY_W + TAG_W + 1] = 1'b1;
				end else begin
					hit_row[w*ENTRY_W + TAG_W + 2] = 1'b1;
				end
			end
			if (WAY_W'(w) == way_q) begin
				fin_row[w*ENTRY_W +: ENTRY_W] = {1'b0, is_write, 1'b1, tag_q};
			end else begin
				fin_row[w*ENTRY_W + TAG_W + 2] = ref_clr_q[w];
			end
		end
		fin_row[ROW_W-1 -: WAY_W] = ptr_next;
	end

	always_comb begin
		stat.clr_done     = (clr_cnt_q == MEM_W'(MEM_WORDS - 1));
		stat.is_preload   = (cmd_q == CMD_PRELOAD);
		stat.is_write     = is_write;
		stat.hit          = hit;
		stat.victim_dirty = e_val[vic_way] & e_dirty[vic_way];
		stat.idx_last     = (idx_q == WORD_W'(LINE_WORDS - 1));
	end

	// Memory port selection.
	always_comb begin
		meta_we = 1'b0;
		meta_wa = set_q;
		meta_wd = fin_row;
		if (cmd.clr_step) begin
			meta_we = (clr_cnt_q[MEM_W-1:SET_W] == '0);
			meta_wa = clr_cnt_q[SET_W-1:0];
			meta_wd = '0;
		end else if (cmd.hit_upd) begin
			meta_we = 1'b1;
			meta_wd = hit_row;
		end else if (cmd.fin_upd) begin
			meta_we = 1'b1;
		end

		line_we = (cmd.hit_upd && is_write) || cmd.fill_wr;
		line_wa = cmd.fill_wr ? {way_q, set_q, idx_q} : {hit_way, set_q, word_q};
		line_wd = cmd.fill_wr ? fill_data : wdata_q;
		line_re = (cmd.hit_upd && !is_write) || cmd.wb_rd;
		line_ra = cmd.wb_rd ? {way_q, set_q, idx_q} : {hit_way, set_q, word_q};

		back_we = cmd.clr_step || cmd.preload_wr || cmd.wb_wr;
		if (cmd.clr_step) begin
			back_wa = clr_cnt_q;
			back_wd = '0;
		end else if (cmd.preload_wr) begin
			back_wa = waddr_q;
			back_wd = wdata_q;
		end else begin
			back_wa = wb_line[MEM_W-1:0];
			back_wd = line_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_wa] <= meta_wd;
		end
		if (cmd.meta_rd) begin
			meta_rd_q <= meta_mem[set_q];
		end
	end

	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[line_wa] <= line_wd;
		end
		if (line_re) begin
			line_rd_q <= line_mem[line_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (back_we) begin
			back_mem[back_wa] <= back_wd;
		end
		if (cmd.fill_rd) begin
			mem_rd_q <= back_mem[{waddr_q[MEM_W-1:WORD_W], idx_q}];
		end
	end

	// Request fields and miss bookkeeping.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q   <= command;
			word_q  <= address[WORD_W+1:2];
			set_q   <= address[SET_W+WORD_W+1:WORD_W+2];
			tag_q   <= address[31:SET_W+WORD_W+2];
			waddr_q <= address[MEM_W+1:2];
			wdata_q <= write_data;
		end
		if (cmd.tag_cap) begin
			way_q       <= hit ? hit_way : vic_way;
			vic_tag_q   <= e_tag[vic_way];
			vic_dirty_q <= e_val[vic_way] & e_dirty[vic_way];
			ref_clr_q   <= ref_new;
		end
		if (cmd.fill_wr && word_match) begin
			miss_word_q <= fill_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			idx_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.latch) begin
				idx_q <= '0;
			end else if (cmd.wb_wr || cmd.fill_wr) begin
				idx_q <= idx_q + 1'b1;
			end
			done_q <= cmd.preload_wr || cmd.emit_write_hit || cmd.emit_read_hit || cmd.fin_upd;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.preload_wr) begin
			read_data_q <= '0;
			outcome_q   <= OUT_PRELOAD;
		end else if (cmd.emit_write_hit) begin
			read_data_q <= wdata_q;
			outcome_q   <= OUT_HIT;
		end else if (cmd.emit_read_hit) begin
			read_data_q <= line_rd_q;
			outcome_q   <= OUT_HIT;
		end else if (cmd.fin_upd) begin
			read_data_q <= miss_word_q;
			outcome_q   <= vic_dirty_q ? OUT_MISS_DIRTY : OUT_MISS_CLEAN;
		end else begin
			read_data_q <= read_data_q;
			outcome_q   <= outcome_q;
		end
	end

	assign done      = done_q;
	assign read_data = $signed(read_data_q);
	assign outcome   = outcome_q;

endmodule

// ===== hw/rtl/set_assoc_cache_second_chance_top.sv =====
// From the accepting edge to the done beat a preload passes dispatch, a write hit dispatch and
// tag check, a read hit these and the hit read, a miss dispatch, tag check, optional write-back,
// refill and the final update. One item is in flight at a time: the next beat is taken at
// the earliest on the edge that ends the done beat. The line transfer, a read and a write
// state per word, sets the miss time. After reset busy is high while a clearing pass zeroes the
// backing memory and per-set tag, state and pointer rows; line data is not cleared. No stalls.
module set_assoc_cache_second_chance_top import sacsc_pkg::*; #(
	parameter int WAYS       = 4,
	parameter int SETS       = 256,
	parameter int LINE_WORDS = 16,
	parameter int MEM_WORDS  = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [31:0]        address,
	input  logic signed [31:0] write_data,
	output logic               done,
	output logic signed [31:0] read_data,
	output logic [1:0]         outcome
);

	// WAYS, SETS, LINE_WORDS and MEM_WORDS are taken as powers of two: the address fields
	// are plain bit slices of the word address and the backing memory wraps on its width.
	// The receiver cannot stall, so each done beat lasts exactly one cycle.

	// The controller sequences one beat at a time: dispatch (a preload ends here), tag check (a
	// write hit ends here), then a hit read, or victim write-back if dirty, refill and final update.
	// The datapath holds the metadata rows, the line memory and the backing memory,
	// all read through registered ports, and the result registers that drive done.
	sacsc_cmd_t  cmd;
	sacsc_stat_t stat;

	sacsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// The tag check also runs the second-chance walk: starting at the set's pointer,
	// referenced ways lose their reference bit until an unreferenced way turns up,
	// and that way becomes the victim. The pointer moves past the victim on refill.
	sacsc_dp #(
		.WAYS       (WAYS),
		.SETS       (SETS),
		.LINE_WORDS (LINE_WORDS),
		.MEM_WORDS  (MEM_WORDS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.command    (command),
		.address    (address),
		.write_data (write_data),
		.done       (done),
		.read_data  (read_data),
		.outcome    (outcome)
	);

endmodule
